@@ hw/rtl/thumb_load_store_unit_assert.svh @@
// Assertion macros for the Thumb load/store unit
`ifndef THUMB_LOAD_STORE_UNIT_ASSERT_SVH
`define THUMB_LOAD_STORE_UNIT_ASSERT_SVH
`define TLSU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TLSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ hw/rtl/tlsu_pkg.sv @@
package tlsu_pkg;
  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_RET   = 2'd1;
  localparam logic [1:0] CMD_WRREG = 2'd2;
  localparam logic [1:0] CMD_RDREG = 2'd3;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_LR = 4'd14;
  localparam logic [3:0] REG_PC = 4'd15;
  localparam int unsigned PEND_DEPTH = 9;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] instr;
    logic [3:0]  reg_index;
    logic [31:0] data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] write_data;
    logic        byte_write;
    logic        branched;
    logic        thumb_state;
    logic        last;
  } out_item_t;
endpackage

@@ hw/rtl/tlsu_fifo.sv @@
module tlsu_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tlsu_pkg::in_item_t din,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output tlsu_pkg::in_item_t dout
);
  import tlsu_pkg::*;
  in_item_t   slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= din;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end
endmodule

@@ hw/rtl/tlsu_exec.sv @@
module tlsu_exec (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  tlsu_pkg::in_item_t  item,
  output logic                in_take,
  output logic                out_valid,
  output tlsu_pkg::out_item_t result,
  input  logic                out_pop
);
  import tlsu_pkg::*;
  typedef enum logic [1:0] {S_IDLE, S_PUSH, S_POP} state_t;

  state_t      state;
  logic [31:0] low_regs [8];
  logic [31:0] sp, lr, pc;
  logic        tbit;
  logic [5:0]  pend [PEND_DEPTH];
  logic [3:0]  pend_count;
  logic [8:0]  list;      // bit 8 is LR/PC
  logic [31:0] msp;

  logic        stall;

  assign stall   = out_valid && !out_pop;
  assign in_take = (state == S_IDLE) && in_valid && !stall;

  // decode helpers
  logic [15:0] ins;
  logic [31:0] a_imm4, a_imm1, a_sp, a_pc, rot_v;
  logic [31:0] base;
  logic [3:0]  lo_list_idx, hi_list_idx;
  logic [8:0]  list_lo_mask;
  logic [5:0]  head;
  logic        is_pushpop;
  assign ins    = item.instr;
  assign base   = low_regs[ins[5:3]];
  assign a_imm4 = base + {25'd0, ins[10:6], 2'b00};
  assign a_imm1 = base + {27'd0, ins[10:6]};
  assign a_sp   = sp + {22'd0, ins[7:0], 2'b00};
  assign a_pc   = pc + {22'd0, ins[7:0], 2'b00};
  assign head   = pend[0];
  assign is_pushpop = (ins[15:12] == 4'hB) && (ins[10:9] == 2'd2);
  always_comb begin
    case (head[5:4])
      2'd1:    rot_v = {item.data[7:0], item.data[31:8]};
      2'd2:    rot_v = {item.data[15:0], item.data[31:16]};
      2'd3:    rot_v = {item.data[23:0], item.data[31:24]};
      default: rot_v = item.data;
    endcase
  end

  // lowest set bit (pop order) and highest set bit (push order) of list
  always_comb begin
    lo_list_idx = 4'd0;
    hi_list_idx = 4'd0;
    for (int i = 8; i >= 0; i--) if (list[i]) lo_list_idx = 4'(i);
    for (int i = 0; i <= 8; i++) if (list[i]) hi_list_idx = 4'(i);
    list_lo_mask = list & (list - 9'd1);
  end

  function automatic out_item_t mk(logic [1:0] k, logic [31:0] a, logic [31:0] w,
                                   logic bw, logic br, logic t, logic l);
    out_item_t r;
    r.kind = k; r.address = a; r.write_data = w; r.byte_write = bw;
    r.branched = br; r.thumb_state = t; r.last = l;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      for (int i = 0; i < 8; i++) low_regs[i] <= '0;
      sp         <= '0;
      lr         <= '0;
      pc         <= '0;
      tbit       <= 1'b1;
      pend_count <= '0;
      list       <= '0;
      msp        <= '0;
    end else begin
      if (out_valid && out_pop) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_take) begin
            out_valid <= 1'b1;
            result    <= mk(KIND_ERROR, '0, '0, 1'b0, 1'b0, tbit, 1'b1);
            case (item.command)
              CMD_EXEC: begin
                if (pend_count != 4'd0) begin
                  // error already set
                end else if (ins[15:11] == 5'b01001) begin
                  result <= mk(KIND_READ, a_pc, '0, 1'b0, 1'b0, tbit, 1'b1);
                  pend[0] <= {2'd0, 1'b0, ins[10:8]};
                  pend_count <= 4'd1;
                end else if (ins[15:13] == 3'b011) begin
                  case (ins[12:11])
                    2'd0: result <= mk(KIND_WRITE, {a_imm4[31:2], 2'b00}, low_regs[ins[2:0]],
                                       1'b0, 1'b0, tbit, 1'b1);
                    2'd1: begin
                      result <= mk(KIND_READ, {a_imm4[31:2], 2'b00}, '0, 1'b0, 1'b0, tbit, 1'b1);
                      pend[0] <= {a_imm4[1:0], 1'b0, ins[2:0]};
                      pend_count <= 4'd1;
                    end
                    2'd2: result <= mk(KIND_WRITE, a_imm1, {24'd0, low_regs[ins[2:0]][7:0]},
                                       1'b1, 1'b0, tbit, 1'b1);
                    default: ;
                  endcase
                end else if (ins[15:12] == 4'h9) begin
                  if (ins[11]) begin
                    result <= mk(KIND_READ, {a_sp[31:2], 2'b00}, '0, 1'b0, 1'b0, tbit, 1'b1);
                    pend[0] <= {a_sp[1:0], 1'b0, ins[10:8]};
                    pend_count <= 4'd1;
                  end else begin
                    result <= mk(KIND_WRITE, {a_sp[31:2], 2'b00}, low_regs[ins[10:8]],
                                 1'b0, 1'b0, tbit, 1'b1);
                  end
                end else if (is_pushpop) begin
                  out_valid <= 1'b0;
                  if (ins[8:0] != 9'd0) begin
                    list  <= ins[8:0];
                    msp   <= sp;
                    state <= ins[11] ? S_POP : S_PUSH;
                  end
                end
              end
              CMD_RET: begin
                if (pend_count != 4'd0) begin
                  for (int i = 0; i < PEND_DEPTH - 1; i++) pend[i] <= pend[i + 1];
                  pend_count <= pend_count - 4'd1;
                  if (head[3:0] == REG_PC) begin
                    tbit <= rot_v[0];
                    pc   <= {rot_v[31:1], 1'b0};
                    result <= mk(KIND_REPORT, 32'(REG_PC), {rot_v[31:1], 1'b0},
                                 1'b0, 1'b1, rot_v[0], 1'b1);
                  end else begin
                    low_regs[head[2:0]] <= rot_v;
                    result <= mk(KIND_REPORT, {28'd0, head[3:0]}, rot_v,
                                 1'b0, 1'b0, tbit, 1'b1);
                  end
                end
              end
              default: begin
                logic [31:0] v;
                logic ok;
                ok = 1'b1;
                v  = item.data;
                if (item.reg_index[3] == 1'b0) begin
                  if (item.command == CMD_WRREG) low_regs[item.reg_index[2:0]] <= item.data;
                  else v = low_regs[item.reg_index[2:0]];
                end else if (item.reg_index == REG_SP) begin
                  if (item.command == CMD_WRREG) sp <= item.data; else v = sp;
                end else if (item.reg_index == REG_LR) begin
                  if (item.command == CMD_WRREG) lr <= item.data; else v = lr;
                end else if (item.reg_index == REG_PC) begin
                  if (item.command == CMD_WRREG) pc <= item.data; else v = pc;
                end else begin
                  ok = 1'b0;
                end
                if (ok) result <= mk(KIND_REPORT, {28'd0, item.reg_index}, v,
                                     1'b0, 1'b0, tbit, 1'b1);
              end
            endcase
          end
        end
        S_POP: begin
          if (!stall) begin
            out_valid <= 1'b1;
            result <= mk(KIND_READ, {msp[31:2], 2'b00}, '0, 1'b0, 1'b0, tbit,
                         list_lo_mask == 9'd0);
            pend[pend_count] <= {2'd0, (lo_list_idx == 4'd8) ? REG_PC : lo_list_idx};
            pend_count <= pend_count + 4'd1;
            msp  <= msp + 32'd4;
            list <= list_lo_mask;
            if (list_lo_mask == 9'd0) begin
              sp    <= msp + 32'd4;
              state <= S_IDLE;
            end
          end
        end
        S_PUSH: begin
          if (!stall) begin
            out_valid <= 1'b1;
            result <= mk(KIND_WRITE, {msp[31:2] - 30'd1, 2'b00},
                         (hi_list_idx == 4'd8) ? lr : low_regs[hi_list_idx[2:0]],
                         1'b0, 1'b0, tbit, (list & ~(9'd1 << hi_list_idx)) == 9'd0);
            msp  <= msp - 32'd4;
            list <= list & ~(9'd1 << hi_list_idx);
            if ((list & ~(9'd1 << hi_list_idx)) == 9'd0) begin
              sp    <= msp - 32'd4;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/thumb_load_store_unit.sv @@
// Thumb load/store unit.
// An item leaves the input queue in the cycle after its push at the earliest. A single
// result is registered as its item is taken; a PUSH/POP first enters its push or pop
// state, then makes one request per list entry (up to 9). Single items go one per cycle
// while results are popped; an unpopped result stalls the unit and its input queue.
// Reset (rst, synchronous): registers zero, Thumb bit one, queues empty.
module thumb_load_store_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tlsu_pkg::in_item_t  item,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output tlsu_pkg::out_item_t result
);
  import tlsu_pkg::*;
`include "thumb_load_store_unit_assert.svh"

  logic     q_empty, q_take, out_valid;
  in_item_t q_item;

  tlsu_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .din(item), .full(full),
    .pop(q_take), .empty(q_empty), .dout(q_item)
  );

  tlsu_exec u_exec (
    .clk(clk), .rst(rst), .in_valid(!q_empty), .item(q_item), .in_take(q_take),
    .out_valid(out_valid), .result(result), .out_pop(pop)
  );

  assign empty = !out_valid;

  `TLSU_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(result),
                    "result changed while waiting")
  `TLSU_ASSERT_IMPL(a_err_clean, clk, rst, !empty && result.kind == KIND_ERROR,
                    result.last && result.address == '0, "bad error result")
endmodule

@@ tb/thumb_load_store_unit_tb.sv @@
`timescale 1ns / 1ps

module thumb_load_store_unit_tb;
  import tlsu_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  in_item_t in_item = '0;
  out_item_t out_item;

  thumb_load_store_unit dut (
    .clk(clk), .rst(rst), .push(push), .item(in_item), .full(full),
    .empty(empty), .pop(pop), .result(out_item)
  );

  always #5 clk = ~clk;

  // predicted register file
  logic [31:0] lo_regs[8];
  logic [31:0] sp_reg, lr_reg, pc_reg;
  logic        t_bit;
  logic [5:0]  load_dest_q[$];
  out_item_t   result_q[$];

  int  fail_count = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  hold_start = 1'b0;
  bit  hold_ack = 1'b0;
  bit  burst_mode = 1'b1;

  function automatic void add_result(input logic [1:0] k, input logic [31:0] a,
                                     input logic [31:0] wd, input logic bw,
                                     input logic br);
    out_item_t r;
    r.kind = k; r.address = a; r.write_data = wd; r.byte_write = bw;
    r.branched = br; r.thumb_state = t_bit; r.last = 1'b0;
    result_q.push_back(r);
  endfunction

  function automatic void predict_exec(input logic [15:0] ins);
    logic [31:0] a, sp;
    logic [2:0] rd, rb;
    if (ins[15:11] == 5'b01001) begin
      rd = ins[10:8];
      add_result(KIND_READ, pc_reg + {22'd0, ins[7:0], 2'b00}, '0, 1'b0, 1'b0);
      load_dest_q.push_back({2'b00, 1'b0, rd});
    end else if (ins[15:13] == 3'b011) begin
      rb = ins[5:3]; rd = ins[2:0];
      case (ins[12:11])
        2'd0: begin
          a = lo_regs[rb] + {25'd0, ins[10:6], 2'b00};
          add_result(KIND_WRITE, a & ~32'd3, lo_regs[rd], 1'b0, 1'b0);
        end
        2'd1: begin
          a = lo_regs[rb] + {25'd0, ins[10:6], 2'b00};
          add_result(KIND_READ, a & ~32'd3, '0, 1'b0, 1'b0);
          load_dest_q.push_back({a[1:0], 1'b0, rd});
        end
        2'd2: begin
          a = lo_regs[rb] + {27'd0, ins[10:6]};
          add_result(KIND_WRITE, a, {24'd0, lo_regs[rd][7:0]}, 1'b1, 1'b0);
        end
        default: add_result(KIND_ERROR, '0, '0, 1'b0, 1'b0);
      endcase
    end else if (ins[15:12] == 4'b1001) begin
      rd = ins[10:8];
      a = sp_reg + {22'd0, ins[7:0], 2'b00};
      if (ins[11]) begin
        add_result(KIND_READ, a & ~32'd3, '0, 1'b0, 1'b0);
        load_dest_q.push_back({a[1:0], 1'b0, rd});
      end else
        add_result(KIND_WRITE, a & ~32'd3, lo_regs[rd], 1'b0, 1'b0);
    end else if (ins[15:12] == 4'b1011 && ins[10:9] == 2'b10) begin
      sp = sp_reg;
      if (ins[11]) begin
        for (int i = 0; i < 8; i++)
          if (ins[i]) begin
            add_result(KIND_READ, sp & ~32'd3, '0, 1'b0, 1'b0);
            load_dest_q.push_back(6'(i));
            sp += 4;
          end
        if (ins[8]) begin
          add_result(KIND_READ, sp & ~32'd3, '0, 1'b0, 1'b0);
          load_dest_q.push_back({2'b00, REG_PC});
          sp += 4;
        end
      end else begin
        if (ins[8]) begin
          sp -= 4;
          add_result(KIND_WRITE, sp & ~32'd3, lr_reg, 1'b0, 1'b0);
        end
        for (int i = 7; i >= 0; i--)
          if (ins[i]) begin
            sp -= 4;
            add_result(KIND_WRITE, sp & ~32'd3, lo_regs[i], 1'b0, 1'b0);
          end
      end
      sp_reg = sp;
    end else
      add_result(KIND_ERROR, '0, '0, 1'b0, 1'b0);
  endfunction

  function automatic void predict_beat(input in_item_t it);
    int n0;
    logic [5:0] e;
    logic [31:0] v;
    logic [4:0] s;
    n0 = result_q.size();
    case (it.command)
      CMD_EXEC: begin
        if (load_dest_q.size() != 0) add_result(KIND_ERROR, '0, '0, 1'b0, 1'b0);
        else predict_exec(it.instr);
      end
      CMD_RET: begin
        if (load_dest_q.size() == 0) add_result(KIND_ERROR, '0, '0, 1'b0, 1'b0);
        else begin
          e = load_dest_q.pop_front();
          s = {e[5:4], 3'b000};
          v = (it.data >> s) | (s == 0 ? 32'd0 : it.data << (6'd32 - s));
          if (e[3:0] == REG_PC) begin
            t_bit = v[0];
            pc_reg = v & ~32'd1;
            add_result(KIND_REPORT, 32'(REG_PC), pc_reg, 1'b0, 1'b1);
          end else begin
            lo_regs[e[2:0]] = v;
            add_result(KIND_REPORT, {28'd0, e[3:0]}, v, 1'b0, 1'b0);
          end
        end
      end
      default: begin
        logic ok;
        ok = 1'b1;
        v = it.data;
        if (it.command == CMD_WRREG) begin
          if (it.reg_index < 8) lo_regs[it.reg_index[2:0]] = it.data;
          else if (it.reg_index == REG_SP) sp_reg = it.data;
          else if (it.reg_index == REG_LR) lr_reg = it.data;
          else if (it.reg_index == REG_PC) pc_reg = it.data;
          else ok = 1'b0;
        end else begin
          if (it.reg_index < 8) v = lo_regs[it.reg_index[2:0]];
          else if (it.reg_index == REG_SP) v = sp_reg;
          else if (it.reg_index == REG_LR) v = lr_reg;
          else if (it.reg_index == REG_PC) v = pc_reg;
          else ok = 1'b0;
        end
        if (ok) add_result(KIND_REPORT, {28'd0, it.reg_index}, v, 1'b0, 1'b0);
        else add_result(KIND_ERROR, '0, '0, 1'b0, 1'b0);
      end
    endcase
    if (result_q.size() > n0) result_q[result_q.size()-1].last = 1'b1;
  endfunction

  // send one beat; push stays high between back-to-back beats
  task automatic send_beat(input in_item_t it);
    if (burst_mode && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_beat(it);
  endtask

  task automatic send_cmd(input logic [1:0] c, input logic [15:0] ins,
                          input logic [3:0] idx, input logic [31:0] d);
    in_item_t it;
    it.command = c; it.instr = ins; it.reg_index = idx; it.data = d;
    send_beat(it);
  endtask

  task automatic drain_loads();
    while (load_dest_q.size() != 0) send_cmd(CMD_RET, 16'($urandom), 4'($urandom), $urandom);
  endtask

  task automatic wait_quiet();
    push <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_instr();
    logic [15:0] r;
    r = 16'($urandom);
    case ($urandom_range(0, 7))
      0: r[15:11] = 5'b01001;
      1, 2: r[15:13] = 3'b011;
      3: r[15:12] = 4'b1001;
      4, 5: begin r[15:12] = 4'b1011; r[10:9] = 2'b10; end
      default: ;
    endcase
    return r;
  endfunction

  task automatic test_directed();
    for (int i = 0; i < 8; i++) send_cmd(CMD_WRREG, '0, 4'(i), $urandom);
    send_cmd(CMD_WRREG, '0, REG_SP, 32'h0000_1000);
    send_cmd(CMD_WRREG, '0, REG_LR, 32'hFFFF_FFFF);
    send_cmd(CMD_WRREG, '0, REG_PC, 32'h0000_0003);
    send_cmd(CMD_RDREG, '0, 4'd9, '0);
    send_cmd(CMD_WRREG, '0, 4'd12, 32'hFFFF_FFFF);
    send_cmd(CMD_RET, '0, '0, 32'h1234_5678);           // unexpected return
    send_cmd(CMD_EXEC, 16'hB5FF, '0, '0);               // push all + LR
    send_cmd(CMD_EXEC, 16'hB400, '0, '0);               // empty list
    send_cmd(CMD_EXEC, 16'hBDFF, '0, '0);               // pop all + PC
    send_cmd(CMD_EXEC, 16'h6000, '0, '0);               // exec while loads pending
    for (int i = 0; i < 8; i++) send_cmd(CMD_RET, '0, '0, $urandom);
    send_cmd(CMD_RET, '0, '0, 32'hFFFF_FFFE);           // PC pop, thumb off
    send_cmd(CMD_EXEC, 16'h4FFF, '0, '0);               // PC-relative
    send_cmd(CMD_RET, '0, '0, 32'hA5A5_5A5A);
    send_cmd(CMD_WRREG, '0, 4'd1, 32'h0000_0003);
    send_cmd(CMD_EXEC, 16'h6FC8, '0, '0);               // LDR unaligned base
    send_cmd(CMD_RET, '0, '0, 32'h1122_3344);
    send_cmd(CMD_EXEC, 16'h77CA, '0, '0);               // STRB
    send_cmd(CMD_EXEC, 16'h7800, '0, '0);               // LDRB
    send_cmd(CMD_EXEC, 16'h0000, '0, '0);               // unknown
    send_cmd(CMD_RDREG, '0, REG_PC, '0);
  endtask

  task automatic test_random(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        send_cmd(CMD_EXEC, rand_instr(), '0, '0);
        if ($urandom_range(0, 9) != 0) drain_loads();
      end else if (k < 8)
        send_cmd($urandom_range(0, 1) ? CMD_WRREG : CMD_RDREG, 16'($urandom),
                 4'($urandom), $urandom);
      else
        send_cmd(CMD_RET, 16'($urandom), 4'($urandom), $urandom);
    end
    drain_loads();
  endtask

  // receiver holds off long while the sender keeps pushing
  task automatic test_backpressure();
    hold_start = ~hold_start;
    burst_mode = 1'b0;
    for (int i = 0; i < 6; i++) send_cmd(CMD_EXEC, 16'hB5FF, '0, '0);
    burst_mode = 1'b1;
    wait_quiet();
  endtask

  // receiver: random stalls, plus a long hold counted here on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_start != hold_ack) begin
      pop <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_ack <= hold_start;
    end else
      pop <= ($urandom_range(0, 3) != 0) || (($urandom_range(0, 63)) < 2);
  end

  // result checker
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && pop && !empty) begin
      if (result_q.size() == 0) begin
        $error("unexpected result beat kind=%0d", out_item.kind);
        fail_count++;
      end else begin
        exp_r = result_q.pop_front();
        if (out_item.kind !== exp_r.kind) begin
          $error("kind exp %0d got %0d", exp_r.kind, out_item.kind); fail_count++;
        end
        if (out_item.address !== exp_r.address) begin
          $error("address exp %h got %h", exp_r.address, out_item.address); fail_count++;
        end
        if (out_item.write_data !== exp_r.write_data) begin
          $error("write_data exp %h got %h", exp_r.write_data, out_item.write_data);
          fail_count++;
        end
        if (out_item.byte_write !== exp_r.byte_write) begin
          $error("byte_write exp %b got %b", exp_r.byte_write, out_item.byte_write);
          fail_count++;
        end
        if (out_item.branched !== exp_r.branched) begin
          $error("branched exp %b got %b", exp_r.branched, out_item.branched); fail_count++;
        end
        if (out_item.thumb_state !== exp_r.thumb_state) begin
          $error("thumb_state exp %b got %b", exp_r.thumb_state, out_item.thumb_state);
          fail_count++;
        end
        if (out_item.last !== exp_r.last) begin
          $error("last exp %b got %b", exp_r.last, out_item.last); fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) lo_regs[i] = '0;
    sp_reg = '0; lr_reg = '0; pc_reg = '0; t_bit = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    burst_mode = 1'b0;
    test_random(12);
    burst_mode = 1'b1;
    test_random(20);
    wait_quiet();
    test_random(10);
    wait_quiet();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
